// ===== hw/rtl/tbpc_pkg.sv =====
// Shared types and constants for the two-button press classifier.
package tbpc_pkg;

  // Press state codes
  localparam logic [1:0] ST_IDLE           = 2'd0;
  localparam logic [1:0] ST_COUNTING       = 2'd1;
  localparam logic [1:0] ST_RELEASED       = 2'd2;
  localparam logic [1:0] ST_BOTH_RELEASING = 2'd3;

  // Event codes
  localparam logic [2:0] EV_NONE         = 3'd0;
  localparam logic [2:0] EV_FIRST_SHORT  = 3'd1;
  localparam logic [2:0] EV_SECOND_SHORT = 3'd2;
  localparam logic [2:0] EV_FIRST_LONG   = 3'd3;
  localparam logic [2:0] EV_SECOND_LONG  = 3'd4;
  localparam logic [2:0] EV_BOTH_SHORT   = 3'd5;
  localparam logic [2:0] EV_BOTH_LONG    = 3'd6;

  // Config port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_PRESS_TICKS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS_TICKS   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE_TICKS      = 3'd4;

  typedef logic [1:0] press_st_t;
  typedef logic [2:0] code_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [7:0]  debounce_threshold;
    logic [15:0] short_press_ticks;
    logic [15:0] long_press_ticks;
    logic [15:0] release_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    debounce_ticks:     8'd5,
    debounce_threshold: 8'd3,
    short_press_ticks:  16'd5,
    long_press_ticks:   16'd100,
    release_ticks:      16'd20
  };

  // Per-tick state of both buttons, tick counters kept apart (width varies)
  typedef struct packed {
    press_st_t [1:0]       ps;
    logic [1:0][7:0]       integ;
    logic [1:0][7:0]       warm;
    logic [1:0]            deb;
    logic                  both;
    code_t                 latched;
    code_t                 event_code;
  } btn_state_t;

  localparam btn_state_t STATE_RESET = '{
    ps:         {ST_IDLE, ST_IDLE},
    integ:      '0,
    warm:       '0,
    deb:        2'b00,
    both:       1'b0,
    latched:    EV_NONE,
    event_code: EV_NONE
  };

endpackage

// ===== hw/rtl/tbpc_if.sv =====
// Request and result channel interfaces of the press classifier.
interface tbpc_in_if;
  logic valid;
  logic ready;
  logic pin_first;
  logic pin_second;
  logic take_code;

  modport source (output valid, output pin_first, output pin_second, output take_code,
                  input ready);
  modport sink   (input valid, input pin_first, input pin_second, input take_code,
                  output ready);
endinterface

interface tbpc_out_if;
  logic       valid;
  logic       ready;
  logic       pressed_first;
  logic       pressed_second;
  logic [2:0] event_code;
  logic [2:0] pending_code;

  modport source (output valid, output pressed_first, output pressed_second,
                  output event_code, output pending_code, input ready);
  modport sink   (input valid, input pressed_first, input pressed_second,
                  input event_code, input pending_code, output ready);
endinterface

// ===== hw/rtl/tbpc_cfg_regs.sv =====
// Configuration register bank of the press classifier.
module tbpc_cfg_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [tbpc_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  logic [tbpc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tbpc_pkg::cfg_t                 cfg_o
);
  import tbpc_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= CFG_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_DEBOUNCE_TICKS:     cfg_r.debounce_ticks     <= cfg_wdata[7:0];
        CFG_DEBOUNCE_THRESHOLD: cfg_r.debounce_threshold <= cfg_wdata[7:0];
        CFG_SHORT_PRESS_TICKS:  cfg_r.short_press_ticks  <= cfg_wdata;
        CFG_LONG_PRESS_TICKS:   cfg_r.long_press_ticks   <= cfg_wdata;
        CFG_RELEASE_TICKS:      cfg_r.release_ticks      <= cfg_wdata;
        default: ;  // unmapped index: dropped
      endcase
    end
  end

  assign cfg_o = cfg_r;

endmodule

// ===== hw/rtl/tbpc_btn_step.sv =====
// One button's debounce and press state update for a single tick.
module tbpc_btn_step #(
  parameter int BTN   = 0,
  parameter int CNT_W = 16
) (
  input  tbpc_pkg::btn_state_t       st_i,
  input  logic [1:0][CNT_W-1:0]      cnt_i,
  input  logic                       raw_i,
  input  tbpc_pkg::cfg_t             cfg_i,
  output tbpc_pkg::btn_state_t       st_o,
  output logic [1:0][CNT_W-1:0]      cnt_o
);
  import tbpc_pkg::*;

  localparam int    CMP_W      = (CNT_W > 16) ? CNT_W : 16;
  localparam code_t SHORT_CODE = (BTN == 0) ? EV_FIRST_SHORT : EV_SECOND_SHORT;
  localparam code_t LONG_CODE  = (BTN == 0) ? EV_FIRST_LONG : EV_SECOND_LONG;

  btn_state_t            st;
  logic [1:0][CNT_W-1:0] cnt;

  function automatic logic cnt_ge(logic [CNT_W-1:0] c, logic [15:0] thr);
    return CMP_W'(c) >= CMP_W'(thr);
  endfunction

  // State change; counter clear is done by the caller
  function automatic btn_state_t enter_st(btn_state_t s, int b, press_st_t nxt);
    btn_state_t r;
    r = s;
    if (s.ps[b] != ST_IDLE && nxt == ST_IDLE) r.warm[b] = '0;
    r.both  = 1'b0;
    r.ps[b] = nxt;
    return r;
  endfunction

  always_comb begin
    st  = st_i;
    cnt = cnt_i;

    // integrator with warm-up hold
    if (raw_i) begin
      if (st.integ[BTN] < cfg_i.debounce_ticks) st.integ[BTN] = st.integ[BTN] + 8'd1;
    end else if (st.integ[BTN] != 8'd0) begin
      st.integ[BTN] = st.integ[BTN] - 8'd1;
    end
    if (st.warm[BTN] < cfg_i.debounce_ticks) begin
      st.warm[BTN] = st.warm[BTN] + 8'd1;
    end else begin
      st.deb[BTN] = (st.integ[BTN] >= cfg_i.debounce_threshold);
    end

    if (st.deb[BTN]) begin
      if (st.ps[BTN] == ST_IDLE) begin
        st = enter_st(st, BTN, ST_COUNTING);
        cnt[BTN] = '0;
      end else if (st.ps[BTN] == ST_COUNTING) begin
        if (cnt[BTN] != '1) cnt[BTN] = cnt[BTN] + 1'b1;
        if (st.both) begin
          if (st.deb[0] && st.deb[1] &&
              cnt_ge(cnt[0], cfg_i.long_press_ticks) &&
              cnt_ge(cnt[1], cfg_i.long_press_ticks)) begin
            st.latched    = EV_BOTH_LONG;
            st.event_code = EV_BOTH_LONG;
            st = enter_st(st, 0, ST_BOTH_RELEASING);
            st = enter_st(st, 1, ST_BOTH_RELEASING);
            cnt = '0;
          end
        end else if (st.deb[0] && st.ps[0] == ST_COUNTING &&
                     st.deb[1] && st.ps[1] == ST_COUNTING) begin
          st.both = 1'b1;
        end else if (cnt_ge(cnt[BTN], cfg_i.long_press_ticks)) begin
          st.latched    = LONG_CODE;
          st.event_code = LONG_CODE;
          st = enter_st(st, BTN, ST_RELEASED);
          cnt[BTN] = '0;
        end
      end
    end else begin
      case (st.ps[BTN])
        ST_COUNTING: begin
          if (cnt[BTN] != '1) cnt[BTN] = cnt[BTN] + 1'b1;
          if (st.both) begin
            if (!st.deb[0] && !st.deb[1]) begin
              if (cnt_ge(cnt[0], cfg_i.short_press_ticks) &&
                  cnt_ge(cnt[1], cfg_i.short_press_ticks)) begin
                st.latched    = EV_BOTH_SHORT;
                st.event_code = EV_BOTH_SHORT;
                st = enter_st(st, 0, ST_BOTH_RELEASING);
                st = enter_st(st, 1, ST_BOTH_RELEASING);
              end else begin
                st = enter_st(st, 0, ST_IDLE);
                st = enter_st(st, 1, ST_IDLE);
              end
              cnt = '0;
            end
          end else if (cnt_ge(cnt[BTN], cfg_i.short_press_ticks)) begin
            st.latched    = SHORT_CODE;
            st.event_code = SHORT_CODE;
            st = enter_st(st, BTN, ST_RELEASED);
            cnt[BTN] = '0;
          end else begin
            st = enter_st(st, BTN, ST_IDLE);
            cnt[BTN] = '0;
          end
        end
        ST_BOTH_RELEASING: begin
          if (!st.deb[0] && !st.deb[1]) begin
            st = enter_st(st, 0, ST_RELEASED);
            st = enter_st(st, 1, ST_RELEASED);
            cnt = '0;
          end
        end
        ST_RELEASED: begin
          if (cnt[BTN] != '1) cnt[BTN] = cnt[BTN] + 1'b1;
          if (cnt_ge(cnt[BTN], cfg_i.release_ticks)) begin
            st = enter_st(st, BTN, ST_IDLE);
            cnt[BTN] = '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign st_o  = st;
  assign cnt_o = cnt;

endmodule

// ===== hw/rtl/two_button_press_classifier_core.sv =====
// Top level of the two-button press classifier.
//
// Usage: every request on in_req is one sample tick carrying the raw pin
// levels (pin_first active low, pin_second active high) and take_code, which
// clears the pending code after this tick's update. Every request yields
// exactly one result on out_res: debounced levels after the tick, the event
// raised in this tick (0 when none) and the pending code before the take.
// Registers are written through cfg_we/cfg_idx/cfg_wdata; write them only
// while no request is in flight. An unmapped index is ignored.
// Path: an accepted request waits in the input register; one pass of both
// button updates then moves its result into the result register.
// Throughput: one request per cycle while out_res.ready is high; the button
// 0 -> button 1 update chain between those two registers sets the clock period.
// Stall: in_req.ready stays high while the input register is free or can
// move into the result register; a held result stalls every request behind it.
// Reset (rst_n low, synchronous): both buttons idle, integrators, warm-up
// counts and tick counters at zero, no pending code, registers at defaults.
module two_button_press_classifier_core #(
  parameter int TICK_COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  tbpc_in_if.sink                         in_req,
  tbpc_out_if.source                      out_res,
  input  logic                            cfg_we,
  input  logic [tbpc_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tbpc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tbpc_pkg::*;

  localparam int CNT_W = TICK_COUNT_BITS;

  cfg_t cfg;

  tbpc_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg_o     (cfg)
  );

  // input register
  logic in_valid_r;
  logic pin_first_r, pin_second_r, take_r;
  // result register
  logic  out_valid_r;
  logic  pressed_first_r, pressed_second_r;
  code_t event_r, pending_r;
  // button state
  btn_state_t            st_r;
  logic [1:0][CNT_W-1:0] cnt_r;

  logic adv;
  logic in_take;

  assign adv     = in_valid_r && (!out_valid_r || out_res.ready);
  assign in_take = in_req.valid && in_req.ready;
  assign in_req.ready = !in_valid_r || adv;

  // two chained button updates: button 1 sees what button 0 left
  btn_state_t            st0, st1, st2;
  logic [1:0][CNT_W-1:0] cnt1, cnt2;

  always_comb begin
    st0 = st_r;
    st0.event_code = EV_NONE;
  end

  tbpc_btn_step #(.BTN(0), .CNT_W(CNT_W)) u_btn0 (
    .st_i  (st0),
    .cnt_i (cnt_r),
    .raw_i (!pin_first_r),
    .cfg_i (cfg),
    .st_o  (st1),
    .cnt_o (cnt1)
  );

  tbpc_btn_step #(.BTN(1), .CNT_W(CNT_W)) u_btn1 (
    .st_i  (st1),
    .cnt_i (cnt1),
    .raw_i (pin_second_r),
    .cfg_i (cfg),
    .st_o  (st2),
    .cnt_o (cnt2)
  );

  btn_state_t st_nxt;

  always_comb begin
    st_nxt = st2;
    if (take_r) st_nxt.latched = EV_NONE;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= STATE_RESET;
      cnt_r       <= '0;
    end else begin
      if (in_take) begin
        in_valid_r <= 1'b1;
      end else if (adv) begin
        in_valid_r <= 1'b0;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
        cnt_r       <= cnt2;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_take) begin
      pin_first_r  <= in_req.pin_first;
      pin_second_r <= in_req.pin_second;
      take_r       <= in_req.take_code;
    end
    if (adv) begin
      pressed_first_r  <= st2.deb[0];
      pressed_second_r <= st2.deb[1];
      event_r          <= st2.event_code;
      pending_r        <= st2.latched;
    end
  end

  assign out_res.valid          = out_valid_r;
  assign out_res.pressed_first  = pressed_first_r;
  assign out_res.pressed_second = pressed_second_r;
  assign out_res.event_code     = event_r;
  assign out_res.pending_code   = pending_r;

endmodule
